FILE: src/tuning_step_and_band_filter_select_core_defines.svh
// ----------------------------------------------------------------------------
// Tuning step and band filter select: assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef TUNING_STEP_AND_BAND_FILTER_SELECT_CORE_DEFINES_SVH
`define TUNING_STEP_AND_BAND_FILTER_SELECT_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TSBFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsbfs: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define TSBFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsbfs: next-cycle check failed");

`endif

FILE: src/tsbfs_pkg.sv
// ----------------------------------------------------------------------------
// Tuning step and band filter select: package
// Item kinds, register indexes, reset values and the default filter limits.
// ----------------------------------------------------------------------------
package tsbfs_pkg;

    // Default table size
    localparam int FILTER_ENTRIES_DEF = 8;

    // Item kinds
    typedef enum logic [2:0] {
        KIND_STEP_UP   = 3'd0,
        KIND_STEP_DOWN = 3'd1,
        KIND_STEP_X10  = 3'd2,
        KIND_STEP_DIV  = 3'd3,
        KIND_SET_STEP  = 3'd4,
        KIND_TUNE      = 3'd5,
        KIND_SET_CODE  = 3'd6,
        KIND_SET_LIMIT = 3'd7
    } kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_FREQ_MULT   = 2'd0,
        CFG_SCREEN_MODE = 2'd1,
        CFG_LOWER_LIMIT = 2'd2,
        CFG_UPPER_LIMIT = 2'd3
    } cfg_idx_t;

    // Reset values
    localparam logic [7:0]  MULT_RST        = 8'd4;
    localparam logic [31:0] LOWER_LIMIT_RST = 32'd1800000;
    localparam logic [31:0] UPPER_LIMIT_RST = 32'd500000000;
    localparam logic [31:0] TUNED_FREQ_RST  = 32'd14070000;
    localparam logic [31:0] STEP_RST        = 32'd100;

    // Step scaling bounds
    localparam logic [31:0] STEP_MAX = 32'd1000000;
    localparam logic [31:0] STEP_MIN = 32'd1;

    // Reciprocal of ten: (x * RECIP10) >> 35 == x / 10 for any 32-bit x
    localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;
    localparam int          RECIP10_SHIFT = 35;

    // Last code marker: bit 3 set means no code emitted yet
    localparam logic [3:0] CODE_NONE = 4'd8;

    // Default upper limit of a table entry
    function automatic logic [31:0] default_limit(input int idx);
        logic [31:0] lim;
        case (idx)
            0:       lim = 32'd3400000;
            1:       lim = 32'd6900000;
            2:       lim = 32'd9900000;
            3:       lim = 32'd13900000;
            4:       lim = 32'd18000000;
            5:       lim = 32'd20900000;
            6:       lim = 32'd27900000;
            default: lim = 32'd500000000;
        endcase
        return lim;
    endfunction

endpackage

FILE: src/tuning_step_and_band_filter_select_core.sv
// ----------------------------------------------------------------------------
// Tuning step and band filter select core
// Keeps tuned frequency, step size and band filter table; issues synthesizer
// drive values and filter select codes.
// ----------------------------------------------------------------------------
// One item can enter per cycle while the output is not stalled. Each taken
// item goes to an input register, then a single execute pass (step/tune,
// limit check, table search, code change, step scaling and the 40-bit drive
// multiply) that updates all state and loads the result register. The rate of
// one item per cycle is set by that pass, where each item's state update is
// combinational and is registered with the result. The input register still
// takes an item while the result register waits on a stalled output, so the
// input stalls only when both registers are full and the output is stalled. The
// configuration port is always ready; write it only while no item is in flight.
// ----------------------------------------------------------------------------
`include "tuning_step_and_band_filter_select_core_defines.svh"

module tuning_step_and_band_filter_select_core #(
    parameter int FILTER_ENTRIES = tsbfs_pkg::FILTER_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,

    // Input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] value,
    input  logic [2:0]  entry_index,
    input  logic [2:0]  entry_code,

    // Result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] current_freq,
    output logic [39:0] drive_freq,
    output logic        drive_update,
    output logic        rejected,
    output logic [2:0]  filter_code,
    output logic        filter_update,
    output logic [31:0] step_now
);

    import tsbfs_pkg::*;

    // Configuration registers
    logic [7:0]  mult_reg;
    logic        screen_reg;
    logic [31:0] lower_reg;
    logic [31:0] upper_reg;

    // Tuning state
    logic [31:0] tuned_reg, tuned_next;
    logic [31:0] step_reg, step_next;
    logic [3:0]  last_reg, last_next;
    logic [31:0] lim_reg [FILTER_ENTRIES];
    logic [31:0] lim_next [FILTER_ENTRIES];
    logic [2:0]  sel_reg [FILTER_ENTRIES];
    logic [2:0]  sel_next [FILTER_ENTRIES];

    // Stage 1: input register
    logic        s1_vld_reg;
    kind_t       s1_kind_reg;
    logic [31:0] s1_value_reg;
    logic [2:0]  s1_idx_reg;
    logic [2:0]  s1_code_reg;

    // Stage 2: result register
    logic        s2_vld_reg;
    logic [31:0] s2_cur_reg;
    logic [39:0] s2_drive_reg;
    logic        s2_dupd_reg;
    logic        s2_rej_reg;
    logic [2:0]  s2_fcode_reg;
    logic        s2_fupd_reg;
    logic [31:0] s2_step_reg;

    // Stage flow control
    logic ld2, ld1, exec;

    // Execute stage signals
    logic [31:0]               attempt;
    logic                      in_window;
    logic [FILTER_ENTRIES-1:0] hit;
    logic                      found;
    logic [2:0]                match_code;
    logic                      idx_ok;
    logic [63:0]               div_prod;
    logic [31:0]               step_div10;
    logic [31:0]               step_x10;
    logic                      dupd, rej, fupd;

    // Handshakes
    assign ld2       = !s2_vld_reg || !out_stall;
    assign ld1       = !s1_vld_reg || ld2;
    assign exec      = s1_vld_reg && ld2;
    assign in_stall  = !ld1;
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg   <= MULT_RST;
            screen_reg <= 1'b0;
            lower_reg  <= LOWER_LIMIT_RST;
            upper_reg  <= UPPER_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FREQ_MULT:   mult_reg   <= cfg_data[7:0];
                CFG_SCREEN_MODE: screen_reg <= cfg_data[0];
                CFG_LOWER_LIMIT: lower_reg  <= cfg_data;
                CFG_UPPER_LIMIT: upper_reg  <= cfg_data;
                default:         mult_reg   <= mult_reg;
            endcase
        end
    end

    // Stage 1 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (ld1)
            s1_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            s1_kind_reg  <= kind_t'(kind);
            s1_value_reg <= value;
            s1_idx_reg   <= entry_index;
            s1_code_reg  <= entry_code;
        end
    end

    // Attempted frequency and limit window
    always_comb
    begin
        case (s1_kind_reg)
            KIND_STEP_UP:   attempt = tuned_reg + step_reg;
            KIND_STEP_DOWN: attempt = tuned_reg - step_reg;
            default:        attempt = s1_value_reg;
        endcase
    end

    assign in_window = (attempt >= lower_reg) && (attempt <= upper_reg);

    // Parallel compare against every table limit
    always_comb
    begin
        for (int i = 0; i < FILTER_ENTRIES; i++)
            hit[i] = (attempt <= lim_reg[i]);
    end

    // Priority pick: lowest matching entry wins
    always_comb
    begin
        found      = 1'b0;
        match_code = 3'd0;
        for (int i = FILTER_ENTRIES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                found      = 1'b1;
                match_code = sel_reg[i];
            end
        end
    end

    // Step scaling
    assign step_x10   = {step_reg[28:0], 3'b000} + {step_reg[30:0], 1'b0};
    assign div_prod   = {32'd0, step_reg} * {32'd0, RECIP10};
    assign step_div10 = {3'b000, div_prod[63:RECIP10_SHIFT]};
    assign idx_ok     = (32'(s1_idx_reg) < 32'(FILTER_ENTRIES));

    // State update for the item in stage 1
    always_comb
    begin
        tuned_next = tuned_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        lim_next   = lim_reg;
        sel_next   = sel_reg;
        dupd       = 1'b0;
        rej        = 1'b0;
        fupd       = 1'b0;
        if (exec)
        begin
            if (s1_kind_reg inside {KIND_STEP_UP, KIND_STEP_DOWN, KIND_TUNE})
            begin
                dupd = in_window;
                rej  = !in_window;
                if (in_window)
                    tuned_next = attempt;
                if (found && ({1'b0, match_code} != last_reg) && !screen_reg)
                begin
                    last_next = {1'b0, match_code};
                    fupd      = 1'b1;
                end
            end
            else
            begin
                case (s1_kind_reg)
                    KIND_STEP_X10:
                    begin
                        if (step_reg < STEP_MAX)
                            step_next = step_x10;
                    end
                    KIND_STEP_DIV:
                    begin
                        if (step_reg > STEP_MIN)
                            step_next = step_div10;
                    end
                    KIND_SET_STEP:
                        step_next = s1_value_reg;
                    KIND_SET_CODE:
                    begin
                        for (int i = 0; i < FILTER_ENTRIES; i++)
                        begin
                            if (idx_ok && (32'(s1_idx_reg) == 32'(i)))
                                sel_next[i] = s1_code_reg;
                        end
                        if (idx_ok && ({1'b0, s1_code_reg} != last_reg))
                        begin
                            last_next = {1'b0, s1_code_reg};
                            fupd      = 1'b1;
                        end
                    end
                    KIND_SET_LIMIT:
                    begin
                        for (int i = 0; i < FILTER_ENTRIES; i++)
                        begin
                            if (idx_ok && (32'(s1_idx_reg) == 32'(i)))
                                lim_next[i] = s1_value_reg;
                        end
                    end
                    default:
                        step_next = step_reg;
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tuned_reg <= TUNED_FREQ_RST;
            step_reg  <= STEP_RST;
            last_reg  <= CODE_NONE;
            for (int i = 0; i < FILTER_ENTRIES; i++)
            begin
                lim_reg[i] <= default_limit(i);
                sel_reg[i] <= 3'(i);
            end
        end
        else
        begin
            tuned_reg <= tuned_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
            lim_reg   <= lim_next;
            sel_reg   <= sel_next;
        end
    end

    // Stage 2 capture, drive value formed on the way in
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (ld2)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            s2_cur_reg   <= tuned_next;
            s2_drive_reg <= {8'd0, tuned_next} * {32'd0, mult_reg};
            s2_dupd_reg  <= dupd;
            s2_rej_reg   <= rej;
            s2_fcode_reg <= last_next[3] ? 3'd0 : last_next[2:0];
            s2_fupd_reg  <= fupd;
            s2_step_reg  <= step_next;
        end
    end

    assign out_valid     = s2_vld_reg;
    assign current_freq  = s2_cur_reg;
    assign drive_freq    = s2_drive_reg;
    assign drive_update  = s2_dupd_reg;
    assign rejected      = s2_rej_reg;
    assign filter_code   = s2_fcode_reg;
    assign filter_update = s2_fupd_reg;
    assign step_now      = s2_step_reg;

    // Checks
    `TSBFS_ASSERT_NOW(a_upd_rej_excl, s2_vld_reg, !(s2_dupd_reg && s2_rej_reg))
    `TSBFS_ASSERT_NOW(a_fupd_has_code, s2_vld_reg && s2_fupd_reg, !last_reg[3])
    `TSBFS_ASSERT_NEXT(a_rej_keeps_freq, exec && rej, tuned_reg == $past(tuned_reg))
    `TSBFS_ASSERT_NOW(a_stall_when_full, in_stall, s1_vld_reg && s2_vld_reg)

endmodule
